FILE: src/csk_pkg.sv
// shared types, constants and coefficient function for the compact-support kernel block
// no dependencies
package csk_pkg;

  localparam int unsigned MAX_DIMS   = 16;
  localparam int unsigned ROOT_STEPS = 16;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DVD_W      = 44;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned H_W        = 62;
  localparam int unsigned COEF_W     = 12;

  // ceil(2^32 / d), exact for the 28-bit partial dividends used here
  localparam logic [31:0] RECIP_3  = 32'd1431655766;
  localparam logic [31:0] RECIP_15 = 32'd286331154;

  localparam logic CFG_KERNEL_ORDER = 1'b0;
  localparam logic CFG_DIMS_IN_USE  = 1'b1;

  typedef struct packed {
    logic signed [31:0] coord_first;
    logic signed [31:0] coord_second;
    logic        [31:0] inv_length_scale;
    logic               last_dim;
  } csk_in_t;

  typedef struct packed {
    logic [30:0] kernel_value;
    logic        in_support;
  } csk_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SAT,
    OP_SQ,
    OP_ACC,
    OP_START,
    OP_ROOT,
    OP_PINIT,
    OP_POW,
    OP_HORN,
    OP_DINIT,
    OP_DIV,
    OP_MHI,
    OP_MLO,
    OP_FIN
  } csk_op_e;

  typedef struct packed {
    csk_op_e          op;
    logic [CNT_W-1:0] idx;
  } csk_cmd_t;

  typedef struct packed {
    logic       last;
    logic       big;
    logic       out_full;
    logic [3:0] expo;
    logic [1:0] deg;
  } csk_stat_t;

  // polynomial coefficient of r^k for order q and exponent base j
  function automatic logic [COEF_W-1:0] coef(input logic [1:0] q, input logic [3:0] j,
                                             input logic [1:0] k);
    int unsigned jj;
    int unsigned v;
    jj = int'(j);
    v  = 0;
    unique case (q)
      2'd0: v = (k == 2'd0) ? 1 : 0;
      2'd1: v = (k == 2'd0) ? 1 : ((k == 2'd1) ? jj + 1 : 0);
      2'd2: begin
        unique case (k)
          2'd0: v = 3;
          2'd1: v = 3 * jj + 6;
          2'd2: v = jj * jj + 4 * jj + 3;
          default: v = 0;
        endcase
      end
      default: begin
        unique case (k)
          2'd0: v = 15;
          2'd1: v = 15 * jj + 45;
          2'd2: v = 6 * jj * jj + 36 * jj + 45;
          default: v = jj * jj * jj + 9 * jj * jj + 23 * jj + 15;
        endcase
      end
    endcase
    return COEF_W'(v);
  endfunction

endpackage

FILE: src/csk_ctrl.sv
// sequencing state machine for the kernel block
// depends on csk_pkg
module csk_ctrl import csk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  csk_stat_t stat_i,
  output csk_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SAT, ST_SQ, ST_ACC, ST_CHK, ST_ROOT, ST_PINIT,
    ST_POW, ST_HORN, ST_DINIT, ST_DIV, ST_MHI, ST_MLO, ST_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.idx = cnt_inc;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_MUL:   cmd_o.op = OP_MUL;
      ST_SAT:   cmd_o.op = OP_SAT;
      ST_SQ:    cmd_o.op = OP_SQ;
      ST_ACC:   cmd_o.op = OP_ACC;
      ST_CHK:   if (stat_i.last) cmd_o.op = OP_START;
      ST_ROOT:  cmd_o.op = OP_ROOT;
      ST_PINIT: cmd_o.op = OP_PINIT;
      ST_POW:   cmd_o.op = OP_POW;
      ST_HORN:  cmd_o.op = OP_HORN;
      ST_DINIT: cmd_o.op = OP_DINIT;
      ST_DIV:   cmd_o.op = OP_DIV;
      ST_MHI:   cmd_o.op = OP_MHI;
      ST_MLO:   cmd_o.op = OP_MLO;
      ST_FIN:   if (!stat_i.out_full) cmd_o.op = OP_FIN;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_SAT;
        ST_SAT:  state_q <= ST_SQ;
        ST_SQ:   state_q <= ST_ACC;
        ST_ACC:  state_q <= ST_CHK;
        ST_CHK: begin
          cnt_q <= '0;
          if (!stat_i.last)    state_q <= ST_IDLE;
          else if (stat_i.big) state_q <= ST_FIN;
          else                 state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt_q <= cnt_inc;
          if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_q <= ST_PINIT;
        end
        ST_PINIT: begin
          cnt_q   <= '0;
          state_q <= ST_POW;
        end
        ST_POW: begin
          cnt_q <= cnt_inc;
          if (cnt_inc == CNT_W'(stat_i.expo)) begin
            cnt_q   <= '0;
            state_q <= (stat_i.deg == 2'd0) ? ST_DINIT : ST_HORN;
          end
        end
        ST_HORN: begin
          cnt_q <= cnt_inc;
          if (cnt_inc == CNT_W'(stat_i.deg)) state_q <= ST_DINIT;
        end
        ST_DINIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_inc;
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= ST_MHI;
        end
        ST_MHI: state_q <= ST_MLO;
        ST_MLO: state_q <= ST_FIN;
        ST_FIN: if (!stat_i.out_full) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/csk_dp.sv
// datapath: accumulator, square root, power, polynomial, divider and output register
// depends on csk_pkg
module csk_dp import csk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csk_in_t   in_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output csk_out_t  out_data_o,
  input  csk_cmd_t  cmd_i,
  output csk_stat_t stat_o
);

  logic [1:0]  order_q;
  logic [4:0]  dims_q;
  logic [63:0] acc_q;
  logic        out_valid_q;
  csk_out_t    out_q;

  logic [32:0] mag_q;
  logic        neg_q;
  logic [31:0] inv_q;
  logic        last_q;
  logic [64:0] prod_q;
  logic [31:0] sv_q;
  logic [63:0] sq_q;
  logic        big_q;
  logic [1:0]  ord_q;
  logic [3:0]  j_q;
  logic [3:0]  e_q;
  logic [31:0] rad_q;
  logic [31:0] root_q;
  logic [31:0] bit_q;
  logic [16:0] t_q;
  logic [30:0] p_q;
  logic [H_W-1:0] h_q;
  logic [DVD_W-1:0] dvd_q;
  logic [19:0] qh_q;
  logic [27:0] y_q;
  logic [44:0] mhi_q;
  logic [60:0] mlo_q;

  logic [32:0] diff;
  logic [48:0] qv;
  logic [31:0] lim;
  logic [64:0] sum;
  logic [4:0]  dims_sat;
  logic [3:0]  j_new;
  logic [31:0] trial;
  logic [47:0] pt;
  logic [1:0]  hk;
  logic [H_W-1:0] hterm;
  logic [H_W-1:0] hmul;
  logic [H_W-1:0] nfull;
  logic [3:0]  den;
  logic [31:0] recip;
  logic [51:0] qh_prod;
  logic [19:0] qh_den;
  logic [19:0] rh;
  logic [59:0] ql_prod;
  logic [45:0] res;

  assign diff     = {in_data_i.coord_first[31], in_data_i.coord_first}
                  - {in_data_i.coord_second[31], in_data_i.coord_second};
  assign qv       = prod_q[64:16];
  assign lim      = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
  assign sum      = {1'b0, acc_q} + {1'b0, sq_q};
  assign dims_sat = (dims_q > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : dims_q;
  assign j_new    = dims_sat[4:1] + {2'b00, order_q} + 4'd1;
  assign trial    = root_q + bit_q;
  assign pt       = {17'd0, p_q} * {31'd0, t_q};
  assign hk       = ord_q - cmd_i.idx[1:0];
  assign hmul     = h_q * {{(H_W-16){1'b0}}, root_q[15:0]};
  assign den      = (ord_q == 2'd3) ? 4'd15 : ((ord_q == 2'd2) ? 4'd3 : 4'd1);
  assign recip    = (ord_q == 2'd3) ? RECIP_15 : RECIP_3;
  // long division in a 20-bit high digit and a 24-bit low digit, each by reciprocal multiplication
  assign qh_prod  = {32'd0, dvd_q[43:24]} * {20'd0, recip};
  assign qh_den   = qh_q * {16'd0, den};
  assign rh       = dvd_q[43:24] - qh_den;
  assign ql_prod  = {32'd0, y_q} * {28'd0, recip};
  assign res      = {1'b0, mhi_q} + {15'd0, mlo_q[60:30]};

  // next coefficient of the Horner recurrence, lined up on the 2^16 grid
  always_comb begin
    hterm = {{(H_W-COEF_W){1'b0}}, coef(ord_q, j_q, hk)};
    unique case (cmd_i.idx[1:0])
      2'd1:    hterm = hterm << 16;
      2'd2:    hterm = hterm << 32;
      2'd3:    hterm = hterm << 48;
      default: hterm = hterm;
    endcase
  end

  always_comb begin
    unique case (ord_q)
      2'd0:    nfull = h_q << 48;
      2'd1:    nfull = h_q << 32;
      2'd2:    nfull = h_q << 16;
      default: nfull = h_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= 2'd0;
      dims_q      <= 5'd1;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KERNEL_ORDER: order_q <= cfg_wdata_i[1:0];
          CFG_DIMS_IN_USE:  dims_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.op == OP_ACC) acc_q <= sum[64] ? '1 : sum[63:0];
      if (cmd_i.op == OP_START) acc_q <= '0;
      if (cmd_i.op == OP_FIN) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        neg_q  <= diff[32];
        mag_q  <= diff[32] ? (33'd0 - diff) : diff;
        inv_q  <= in_data_i.inv_length_scale;
        last_q <= in_data_i.last_dim;
      end
      OP_MUL: prod_q <= {32'd0, mag_q} * {33'd0, inv_q};
      OP_SAT: sv_q <= (qv > {17'd0, lim}) ? lim : qv[31:0];
      OP_SQ:  sq_q <= {32'd0, sv_q} * {32'd0, sv_q};
      OP_START: begin
        big_q  <= |acc_q[63:32];
        rad_q  <= acc_q[31:0];
        root_q <= '0;
        bit_q  <= 32'h4000_0000;
        ord_q  <= order_q;
        j_q    <= j_new;
        e_q    <= (order_q == 2'd0) ? j_new : j_new + {2'b00, order_q};
      end
      OP_ROOT: begin
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_PINIT: begin
        t_q <= 17'h1_0000 - {1'b0, root_q[15:0]};
        p_q <= 31'h4000_0000;
        h_q <= {{(H_W-COEF_W){1'b0}}, coef(ord_q, j_q, ord_q)};
      end
      OP_POW:  p_q <= pt[46:16];
      OP_HORN: h_q <= hmul + hterm;
      OP_DINIT: dvd_q <= nfull[DVD_W+17:18];
      OP_DIV: begin
        unique case (cmd_i.idx[1:0])
          2'd1:    qh_q <= qh_prod[51:32];
          2'd2:    y_q  <= {rh[3:0], dvd_q[23:0]};
          default: if (den != 4'd1) dvd_q <= {qh_q, ql_prod[55:32]};
        endcase
      end
      OP_MHI: mhi_q <= {14'd0, p_q} * {31'd0, dvd_q[43:30]};
      OP_MLO: mlo_q <= {30'd0, p_q} * {31'd0, dvd_q[29:0]};
      OP_FIN: begin
        out_q.in_support   <= !big_q;
        out_q.kernel_value <= big_q ? 31'd0 :
                              ((res > 46'h4000_0000) ? 31'h4000_0000 : res[30:0]);
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.last     = last_q;
  assign stat_o.big      = |acc_q[63:32];
  assign stat_o.out_full = out_valid_q;
  assign stat_o.expo     = e_q;
  assign stat_o.deg      = ord_q;

endmodule

FILE: src/compact_support_kernel_eval.sv
// top level of the compact-support piecewise polynomial kernel evaluator
// depends on csk_pkg, csk_ctrl and csk_dp
//
// One input transaction carries one dimension of a point pair: both coordinates
// (signed Q16.16), the reciprocal length scale (unsigned Q16.16) and a last-dimension
// flag. The squared scaled difference is added into a saturating Q32.32 sum.
// On the last dimension one output transaction carries the kernel value (Q1.30)
// and an in-support flag, and the sum is cleared.
// A dimension that is not the last passes through the multiply, saturate, square,
// add and check steps in turn before the next acceptance. When in support, the last
// dimension then runs a 16-step square root, a setup step, e multiplies for (1-r)^e
// (e = exponent), q Horner steps (q = order), a divider setup step, a 3-step
// reciprocal divide by 3 or 15, the high and low halves of the final multiply and
// the output step; outside support the check step goes straight to the output step.
// The result sits in an output register, so the next transaction is accepted
// while it waits; a stalled result holds until taken, and the final step of
// the next pair waits for the register to free.
// Reset (rst_ni low) clears the sum, sets order 0 and one dimension, and drops
// any pending output. Configuration writes are taken on cfg_we_i at any time.
module compact_support_kernel_eval import csk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  csk_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output csk_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [4:0] cfg_wdata_i
);

  csk_cmd_t  cmd;
  csk_stat_t stat;

  csk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  csk_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

FILE: test/compact_support_kernel_eval_test.sv
// self-checking testbench for the compact-support kernel evaluator
// depends on csk_pkg and compact_support_kernel_eval; prediction held in a scoreboard class
`timescale 1ns / 100ps

module compact_support_kernel_eval_test;
  import csk_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_TICKS = 150;
  localparam int unsigned RANDOM_ITEMS = 1250;

  class kernel_scoreboard;
    logic [1:0]  order_q;
    logic [4:0]  dims_q;
    logic [63:0] dist_sum;
    csk_out_t    expected_kernels[$];
    int unsigned errors;

    function new();
      order_q  = 2'd0;
      dims_q   = 5'd1;
      dist_sum = '0;
      errors   = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void set_config(logic [1:0] q, logic [4:0] d);
      order_q = q;
      dims_q  = d;
    endfunction

    function int pending();
      return expected_kernels.size();
    endfunction

    function logic [63:0] int_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rb;
      res = 0;
      rb  = 64'd1 << 30;
      while (rb > v) rb = rb >> 2;
      while (rb != 0) begin
        if (v >= res + rb) begin
          v   = v - (res + rb);
          res = (res >> 1) + rb;
        end else begin
          res = res >> 1;
        end
        rb = rb >> 2;
      end
      return res;
    endfunction

    function logic [63:0] scaled_square(csk_in_t it);
      logic signed [63:0] diff;
      logic [63:0] mag, sd, lim;
      logic neg;
      diff = 64'(it.coord_first) - 64'(it.coord_second);
      neg  = diff < 0;
      mag  = neg ? 64'(-diff) : 64'(diff);
      sd   = (mag * 64'(it.inv_length_scale)) >> 16;
      lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (sd > lim) sd = lim;
      return sd * sd;
    endfunction

    function logic [30:0] predict_kernel(logic [63:0] r, logic [1:0] q, logic [63:0] dims);
      logic [63:0] j, e, t, p, n48, den, poly, res, c1, c2, c3;
      j = dims / 2 + 64'(q) + 1;
      e = (q == 2'd0) ? j : j + 64'(q);
      t = 64'd65536 - r;
      p = 64'd1 << 30;
      for (int i = 0; i < int'(e); i++) p = (p * t) >> 16;
      case (q)
        2'd0: begin
          n48 = 64'd1 << 48;
          den = 1;
        end
        2'd1: begin
          n48 = ((j + 1) * r + (64'd1 << 16)) << 32;
          den = 1;
        end
        2'd2: begin
          c1  = 3 * j + 6;
          c2  = j * j + 4 * j + 3;
          n48 = ((c2 * r + (c1 << 16)) * r + (64'd3 << 32)) << 16;
          den = 3;
        end
        default: begin
          c1  = 15 * j + 45;
          c2  = 6 * j * j + 36 * j + 45;
          c3  = j * j * j + 9 * j * j + 23 * j + 15;
          n48 = ((c3 * r + (c2 << 16)) * r + (c1 << 32)) * r + (64'd15 << 48);
          den = 15;
        end
      endcase
      poly = n48 / (den << 18);
      res  = p * (poly >> 30) + ((p * (poly & 64'h3FFF_FFFF)) >> 30);
      if (res > (64'd1 << 30)) res = 64'd1 << 30;
      return res[30:0];
    endfunction

    function void note_input(csk_in_t it);
      logic [63:0] sq, dims;
      csk_out_t exp_res;
      sq = scaled_square(it);
      if (dist_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) dist_sum = 64'hFFFF_FFFF_FFFF_FFFF;
      else dist_sum = dist_sum + sq;
      if (!it.last_dim) return;
      dims = (dims_q > MAX_DIMS) ? 64'(MAX_DIMS) : 64'(dims_q);
      if (dist_sum >= (64'd1 << 32)) begin
        exp_res.kernel_value = '0;
        exp_res.in_support   = 1'b0;
      end else begin
        exp_res.kernel_value = predict_kernel(int_root(dist_sum), order_q, dims);
        exp_res.in_support   = 1'b1;
      end
      expected_kernels.push_back(exp_res);
      dist_sum = '0;
    endfunction

    function void check_result(csk_out_t got);
      csk_out_t want;
      if (expected_kernels.size() == 0) begin
        report($sformatf("unexpected result value=%h support=%b",
                         got.kernel_value, got.in_support));
        return;
      end
      want = expected_kernels.pop_front();
      if (got.kernel_value !== want.kernel_value)
        report($sformatf("kernel_value got %h want %h", got.kernel_value, want.kernel_value));
      if (got.in_support !== want.in_support)
        report($sformatf("in_support got %b want %b", got.in_support, want.in_support));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  csk_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  csk_out_t   out_data_o;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [4:0] cfg_wdata_i;

  kernel_scoreboard sb;
  int unsigned      cycle_count;
  int unsigned      send_idle_pct;
  int unsigned      stall_pct;
  int unsigned      hold_left;

  compact_support_kernel_eval u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver: long hold-off first, otherwise random stall
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_config(logic [1:0] q, logic [4:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_KERNEL_ORDER;
    cfg_wdata_i <= {3'b0, q};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DIMS_IN_USE;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(q, d);
  endtask

  task automatic send_item(csk_in_t it);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and let every expected result and any trailing work finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  function automatic csk_in_t make_item(logic signed [31:0] a, logic signed [31:0] b,
                                        logic [31:0] inv, logic last);
    csk_in_t it;
    it.coord_first      = a;
    it.coord_second     = b;
    it.inv_length_scale = inv;
    it.last_dim         = last;
    return it;
  endfunction

  // mostly pairs near the support boundary, some fully random noise
  function automatic csk_in_t random_dim(logic last);
    logic [31:0] a, d;
    if ($urandom_range(99) < 25)
      return make_item($urandom, $urandom, $urandom, last);
    a = $urandom;
    d = $urandom_range(0, 60000) - 30000;
    return make_item(a, a - d, $urandom_range(0, 65536), last);
  endfunction

  task automatic random_pairs(int unsigned n_items);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 6);
      for (int k = 1; k <= int'(len); k++) send_item(random_dim(k == int'(len)));
      sent += len;
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_KERNEL_ORDER;
    cfg_wdata_i   = '0;
    cycle_count   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: zero distance gives exactly one
    send_item(make_item(32'sd0, 32'sd0, 32'd0, 1'b1));
    // saturation in both directions, then an accumulator overflow
    send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
    send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    for (int k = 0; k < 4; k++)
      send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, k == 3));
    drain();
    for (int q = 0; q < 4; q++) begin
      write_config(q[1:0], (q == 0) ? 5'd0 : ((q == 3) ? 5'd31 : 5'd16));
      send_item(make_item(32'sd0, 32'sd0, 32'hFFFF_FFFF, 1'b1));
      send_item(make_item(32'h0000_8000, 32'sd0, 32'h0001_0000, 1'b1));
      send_item(make_item(32'h0001_0000, 32'sd0, 32'h0001_0000, 1'b1));
      drain();
    end
    // order and dimension count changed between dimensions of one pair
    send_item(make_item(32'h0000_4000, 32'sd0, 32'h0001_0000, 1'b0));
    drain();
    write_config(2'd2, 5'd17);
    send_item(make_item(32'sd0, 32'h0000_4000, 32'h0001_0000, 1'b1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        write_config(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
        // receiver holds off while the sender keeps offering
        if (ph == 0 && sub == 1) hold_left = 600;
        random_pairs(RANDOM_ITEMS / 8);
        drain();
      end
    end

    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
